/* rtl/lfg_pkg.sv */
// Shared types, constants and the glow table for the lamp flash and glow sequencer.
package lfg_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_AT        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CYCLE_TOTAL     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_PERIOD    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_STEP     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT_FLASH    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORTEST_PERIOD = 3'd6;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ARM  = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;

    localparam logic MODE_FLASH = 1'b0;
    localparam logic MODE_GLOW  = 1'b1;

    localparam logic [7:0]  CYCLES_ENDLESS = 8'hFF;
    localparam logic [3:0]  GLOW_LAST_STEP = 4'd15;
    localparam logic [1:0]  GLOW_OFF       = 2'd3;
    localparam logic [1:0]  DIM_OFF_LEVEL  = 2'd1;
    localparam logic [15:0] PERIOD_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_time;
        logic [7:0]  lamp_number;
    } lfg_in_t;

    typedef struct packed {
        logic [7:0] lamp_out;
        logic       lamp_on;
        logic [1:0] dim_level;
    } lfg_out_t;

    typedef struct packed {
        logic        effect_mode;
        logic [31:0] start_at;
        logic [7:0]  cycle_total;
        logic [15:0] first_period;
        logic [15:0] period_step;
        logic        invert_flash;
        logic [15:0] shortest_period;
    } lfg_cfg_t;

    typedef struct packed {
        logic       running;
        logic [7:0] cycles_left;
    } lfg_status_t;

    // Glow table entry: GLOW_OFF marks a dark step, anything else is the dim level.
    function automatic logic [1:0] glow_entry(input logic [3:0] idx);
        logic [1:0] e;
        unique case (idx)
            4'd0, 4'd1, 4'd2, 4'd14, 4'd15: e = 2'd0;
            4'd3, 4'd13:                    e = 2'd1;
            4'd4, 4'd12:                    e = 2'd2;
            default:                        e = GLOW_OFF;
        endcase
        return e;
    endfunction

endpackage

/* rtl/lamp_flash_glow_sequencer_core.sv */
// Top level of the lamp flash and glow sequencer with its input and result registers.
// A result word for a due tick word is formed between the input register and the result register.
// Throughput: one input word per cycle unless out_ready stalls it; the step logic between
// the input and result registers updates the effect state in that same cycle.
// A full result register stalls the input register only while out_ready is low.
// Reset is asynchronous and active low and clears configuration, state and valid flags.
module lamp_flash_glow_sequencer_core #(
    parameter int LAMP_COUNT = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  lfg_pkg::lfg_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output lfg_pkg::lfg_out_t                out_data,
    input  logic                             cfg_we,
    input  logic [lfg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lfg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import lfg_pkg::*;

    logic        in_valid_reg;
    lfg_in_t     in_word_reg;
    logic        out_valid_reg;
    lfg_out_t    out_word_reg;
    logic        advance;
    logic        emit;
    lfg_out_t    result;
    lfg_cfg_t    cfg;
    lfg_status_t status;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    lfg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lfg_engine #(
        .LAMP_COUNT (LAMP_COUNT)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_word_reg),
        .cfg    (cfg),
        .emit   (emit),
        .result (result),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_data;
        end
        if (advance && emit)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("Input register empty but in_ready is low.");

    a_emit_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |-> (in_word_reg.cmd == CMD_TICK))
        else $error("Result produced by a word that is not a tick.");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_word_reg.cmd == CMD_STOP) |=>
            (!status.running && status.cycles_left == 8'd0))
        else $error("Stop did not clear the running effect.");

    a_lamp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ({1'b0, out_word_reg.lamp_out} < 9'(LAMP_COUNT)))
        else $error("Result names a lamp beyond the lamp count.");

endmodule

/* rtl/lfg_cfg_regs.sv */
// Configuration register file written through the plain write port.
module lfg_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lfg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lfg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output lfg_pkg::lfg_cfg_t                   cfg
);
    import lfg_pkg::*;

    lfg_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EFFECT_MODE:     cfg_reg.effect_mode     <= cfg_wdata[0];
                REG_START_AT:        cfg_reg.start_at        <= cfg_wdata[31:0];
                REG_CYCLE_TOTAL:     cfg_reg.cycle_total     <= cfg_wdata[7:0];
                REG_FIRST_PERIOD:    cfg_reg.first_period    <= cfg_wdata[15:0];
                REG_PERIOD_STEP:     cfg_reg.period_step     <= cfg_wdata[15:0];
                REG_INVERT_FLASH:    cfg_reg.invert_flash    <= cfg_wdata[0];
                REG_SHORTEST_PERIOD: cfg_reg.shortest_period <= cfg_wdata[15:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/lfg_engine.sv */
// Effect state and the single-pass step logic for arm, stop and tick words.
module lfg_engine #(
    parameter int LAMP_COUNT = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  lfg_pkg::lfg_in_t      item,
    input  lfg_pkg::lfg_cfg_t     cfg,
    output logic                  emit,
    output lfg_pkg::lfg_out_t     result,
    output lfg_pkg::lfg_status_t  status
);
    import lfg_pkg::*;

    logic        running_reg,      running_next;
    logic        running_mode_reg, running_mode_next;
    logic [31:0] begin_time_reg,   begin_time_next;
    logic [7:0]  cycles_left_reg,  cycles_left_next;
    logic [15:0] cur_period_reg,   cur_period_next;
    logic [3:0]  step_index_reg,   step_index_next;
    logic [31:0] due_time_reg,     due_time_next;
    logic        flash_inv_reg,    flash_inv_next;
    logic [15:0] run_step_reg,     run_step_next;

    logic              lamp_ok;
    logic              due;
    logic              cycle_done;
    logic [1:0]        glow_e;
    logic signed [17:0] period_sum;
    logic [15:0]       period_upd;
    logic [15:0]       period_use;

    assign lamp_ok = {1'b0, item.lamp_number} < 9'(LAMP_COUNT);
    assign due     = lamp_ok && running_reg && (item.now_time >= begin_time_reg)
                     && (item.now_time >= due_time_reg);
    assign glow_e  = glow_entry(step_index_reg);
    assign cycle_done = (running_mode_reg == MODE_FLASH) ? (step_index_reg != 4'd0)
                                                         : (step_index_reg == GLOW_LAST_STEP);

    assign period_sum = $signed({2'b00, cur_period_reg})
                        + 18'($signed(run_step_reg));

    always_comb
    begin
        if (period_sum < $signed({2'b00, cfg.shortest_period}))
        begin
            period_upd = cfg.shortest_period;
        end
        else if (period_sum > $signed({2'b00, PERIOD_MAX}))
        begin
            period_upd = PERIOD_MAX;
        end
        else
        begin
            period_upd = period_sum[15:0];
        end
    end

    assign period_use = cycle_done ? period_upd : cur_period_reg;

    always_comb
    begin
        running_next      = running_reg;
        running_mode_next = running_mode_reg;
        begin_time_next   = begin_time_reg;
        cycles_left_next  = cycles_left_reg;
        cur_period_next   = cur_period_reg;
        step_index_next   = step_index_reg;
        due_time_next     = due_time_reg;
        flash_inv_next    = flash_inv_reg;
        run_step_next     = run_step_reg;
        emit              = 1'b0;

        if (fire)
        begin
            priority if (item.cmd == CMD_ARM)
            begin
                if (cfg.effect_mode == MODE_GLOW || cycles_left_reg == 8'd0)
                begin
                    running_next      = 1'b1;
                    running_mode_next = cfg.effect_mode;
                    begin_time_next   = cfg.start_at;
                    cycles_left_next  = cfg.cycle_total;
                    cur_period_next   = cfg.first_period;
                    run_step_next     = cfg.period_step;
                    if (cfg.effect_mode == MODE_FLASH)
                    begin
                        flash_inv_next = cfg.invert_flash;
                        due_time_next  = cfg.start_at + 32'(cfg.first_period >> 1);
                    end
                    else
                    begin
                        due_time_next  = cfg.start_at + 32'(cfg.first_period >> 4);
                    end
                end
            end
            else if (item.cmd == CMD_STOP)
            begin
                running_next     = 1'b0;
                cycles_left_next = 8'd0;
            end
            else if (item.cmd == CMD_TICK && due)
            begin
                emit = 1'b1;
                if (cycle_done)
                begin
                    step_index_next = 4'd0;
                    cur_period_next = period_upd;
                    if (cycles_left_reg != CYCLES_ENDLESS)
                    begin
                        if (cycles_left_reg != 8'd0)
                        begin
                            cycles_left_next = cycles_left_reg - 8'd1;
                        end
                        else
                        begin
                            running_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    step_index_next = step_index_reg + 4'd1;
                end
                if (running_mode_reg == MODE_FLASH)
                begin
                    due_time_next = item.now_time + 32'(period_use >> 1);
                end
                else
                begin
                    due_time_next = item.now_time + 32'(period_use >> 4);
                end
            end
            else
            begin
                emit = 1'b0;
            end
        end
    end

    always_comb
    begin
        result.lamp_out = item.lamp_number;
        if (running_mode_reg == MODE_FLASH)
        begin
            result.lamp_on   = (step_index_reg ^ {3'b000, flash_inv_reg}) != 4'd0;
            result.dim_level = 2'd0;
        end
        else if (glow_e == GLOW_OFF)
        begin
            result.lamp_on   = 1'b0;
            result.dim_level = DIM_OFF_LEVEL;
        end
        else
        begin
            result.lamp_on   = 1'b1;
            result.dim_level = glow_e;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg      <= 1'b0;
            running_mode_reg <= 1'b0;
            begin_time_reg   <= '0;
            cycles_left_reg  <= '0;
            cur_period_reg   <= '0;
            step_index_reg   <= '0;
            due_time_reg     <= '0;
            flash_inv_reg    <= 1'b0;
            run_step_reg     <= '0;
        end
        else
        begin
            running_reg      <= running_next;
            running_mode_reg <= running_mode_next;
            begin_time_reg   <= begin_time_next;
            cycles_left_reg  <= cycles_left_next;
            cur_period_reg   <= cur_period_next;
            step_index_reg   <= step_index_next;
            due_time_reg     <= due_time_next;
            flash_inv_reg    <= flash_inv_next;
            run_step_reg     <= run_step_next;
        end
    end

    assign status.running     = running_reg;
    assign status.cycles_left = cycles_left_reg;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the lamp flash and glow sequencer core.
`timescale 1ns / 100ps

module tb_top;
    import lfg_pkg::*;

    localparam int LAMPS = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_PHASES = 40;
    localparam int WORDS_PER_PHASE = 37;
    localparam int MAX_REPORTS = 20;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [31:0] GLOW_STEPS =
        {2'd0, 2'd0, 2'd1, 2'd2, {7{GLOW_OFF}}, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    lfg_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    lfg_out_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int words_sent = 0;
    int lamps_checked = 0;
    int settings_applied = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    logic [31:0] sim_now = '0;

    lfg_cfg_t cfg_shadow = '0;
    logic fx_active = 1'b0;
    logic fx_mode = MODE_FLASH;
    logic [31:0] fx_begin = '0;
    logic [7:0] fx_cycles = '0;
    logic [15:0] fx_period = '0;
    logic [3:0] fx_step = '0;
    logic [31:0] fx_due = '0;
    logic fx_invert = 1'b0;
    shortint fx_accel = 0;

    lfg_out_t pending_lamp_states[$];
    lfg_out_t head_lamp;

    lamp_flash_glow_sequencer_core #(
        .LAMP_COUNT(LAMPS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
        begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
        mismatches++;
    endtask

    task automatic advance_effect(input lfg_in_t w);
        lfg_out_t r;
        logic [3:0] last;
        logic [1:0] e;
        int np;
        if (w.cmd == CMD_ARM)
        begin
            if (cfg_shadow.effect_mode == MODE_GLOW || fx_cycles == 8'd0)
            begin
                fx_mode = cfg_shadow.effect_mode;
                fx_begin = cfg_shadow.start_at;
                fx_cycles = cfg_shadow.cycle_total;
                fx_period = cfg_shadow.first_period;
                fx_accel = cfg_shadow.period_step;
                fx_active = 1'b1;
                if (cfg_shadow.effect_mode == MODE_FLASH)
                begin
                    fx_invert = cfg_shadow.invert_flash;
                    fx_due = cfg_shadow.start_at + {17'd0, cfg_shadow.first_period[15:1]};
                end
                else
                begin
                    fx_due = cfg_shadow.start_at + {20'd0, cfg_shadow.first_period[15:4]};
                end
            end
        end
        else if (w.cmd == CMD_STOP)
        begin
            fx_active = 1'b0;
            fx_cycles = 8'd0;
        end
        else if (w.cmd == CMD_TICK && int'(w.lamp_number) < LAMPS && fx_active
                 && w.now_time >= fx_begin && w.now_time >= fx_due)
        begin
            r.lamp_out = w.lamp_number;
            if (fx_mode == MODE_FLASH)
            begin
                r.lamp_on = ((fx_step ^ {3'b000, fx_invert}) != 4'd0);
                r.dim_level = 2'd0;
                last = 4'd1;
            end
            else
            begin
                e = GLOW_STEPS[2 * fx_step +: 2];
                r.lamp_on = (e != GLOW_OFF);
                r.dim_level = (e == GLOW_OFF) ? DIM_OFF_LEVEL : e;
                last = GLOW_LAST_STEP;
            end
            if (fx_step >= last)
            begin
                fx_step = 4'd0;
                if (fx_cycles != CYCLES_ENDLESS)
                begin
                    if (fx_cycles != 8'd0)
                    begin
                        fx_cycles = fx_cycles - 8'd1;
                    end
                    else
                    begin
                        fx_active = 1'b0;
                    end
                end
                np = int'(fx_period) + int'(fx_accel);
                if (np < int'(cfg_shadow.shortest_period))
                begin
                    np = int'(cfg_shadow.shortest_period);
                end
                if (np > int'(PERIOD_MAX))
                begin
                    np = int'(PERIOD_MAX);
                end
                fx_period = np[15:0];
            end
            else
            begin
                fx_step = fx_step + 4'd1;
            end
            if (fx_mode == MODE_FLASH)
            begin
                fx_due = w.now_time + {17'd0, fx_period[15:1]};
            end
            else
            begin
                fx_due = w.now_time + {20'd0, fx_period[15:4]};
            end
            pending_lamp_states.push_back(r);
        end
    endtask

    task automatic send_word(input logic [1:0] cmd, input logic [31:0] now,
                             input logic [7:0] lamp);
        lfg_in_t w;
        w.cmd = cmd;
        w.now_time = now;
        w.lamp_number = lamp;
        @(negedge clk);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        advance_effect(w);
        words_sent++;
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input lfg_cfg_t s);
        put_reg(REG_EFFECT_MODE, 32'(s.effect_mode));
        put_reg(REG_START_AT, s.start_at);
        put_reg(REG_CYCLE_TOTAL, 32'(s.cycle_total));
        put_reg(REG_FIRST_PERIOD, 32'(s.first_period));
        put_reg(REG_PERIOD_STEP, 32'(s.period_step));
        put_reg(REG_INVERT_FLASH, 32'(s.invert_flash));
        put_reg(REG_SHORTEST_PERIOD, 32'(s.shortest_period));
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_shadow = s;
        settings_applied++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_lamp_states.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic test_quiet_after_reset();
        send_word(CMD_TICK, 32'd0, 8'd0);
        send_word(CMD_SPARE, 32'hFFFF_FFFF, 8'hFF);
        send_word(CMD_STOP, 32'd0, 8'd0);
    endtask

    task automatic test_flash_directed();
        lfg_cfg_t s;
        s.effect_mode = MODE_FLASH;
        s.start_at = 32'd100;
        s.cycle_total = 8'd1;
        s.first_period = 16'd20;
        s.period_step = 16'd4;
        s.invert_flash = 1'b1;
        s.shortest_period = 16'd10;
        settle();
        apply_settings(s);
        send_word(CMD_ARM, 32'd0, 8'd0);
        send_word(CMD_TICK, 32'd50, 8'd5);
        send_word(CMD_TICK, 32'd105, 8'd5);
        send_word(CMD_TICK, 32'd110, 8'd63);
        send_word(CMD_ARM, 32'd110, 8'd0);
        send_word(CMD_TICK, 32'd120, 8'd64);
        send_word(CMD_TICK, 32'd120, 8'd0);
        send_word(CMD_STOP, 32'd120, 8'd0);
    endtask

    task automatic test_glow_directed();
        lfg_cfg_t s;
        s.effect_mode = MODE_GLOW;
        s.start_at = 32'hFFFF_FFF0;
        s.cycle_total = 8'd0;
        s.first_period = 16'd0;
        s.period_step = 16'h8000;
        s.invert_flash = 1'b0;
        s.shortest_period = 16'hFFFF;
        settle();
        apply_settings(s);
        send_word(CMD_ARM, 32'd0, 8'd0);
        for (int i = 0; i < 16; i++)
        begin
            send_word(CMD_TICK, 32'hFFFF_FFF0 + 32'(i), 8'(63 - i));
        end
    endtask

    task automatic run_phase();
        lfg_cfg_t s;
        int pick;
        int counted;
        logic [31:0] span;
        s.effect_mode = 1'($urandom_range(1));
        s.invert_flash = 1'($urandom_range(1));
        pick = $urandom_range(9);
        s.cycle_total = (pick == 0) ? 8'd0 : (pick == 1) ? CYCLES_ENDLESS :
                        (pick == 2) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
        pick = $urandom_range(9);
        s.first_period = (pick == 0) ? 16'd0 : (pick == 1) ? PERIOD_MAX :
                         (pick == 2) ? 16'($urandom()) : 16'($urandom_range(1, 200));
        pick = $urandom_range(9);
        s.period_step = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF :
                        (pick < 4) ? 16'($urandom()) : 16'($urandom_range(40) - 20);
        pick = $urandom_range(19);
        s.shortest_period = (pick < 2) ? 16'd0 : (pick == 2) ? PERIOD_MAX :
                            (pick < 5) ? 16'($urandom()) : 16'($urandom_range(100));
        if ($urandom_range(7) == 0)
        begin
            sim_now = $urandom();
        end
        pick = $urandom_range(7);
        s.start_at = (pick == 0) ? $urandom() : (pick == 1) ? sim_now - $urandom_range(500) :
                     sim_now + $urandom_range(50);
        settle();
        apply_settings(s);
        send_word(CMD_ARM, $urandom(), 8'($urandom_range(255)));
        counted = 0;
        while (counted < WORDS_PER_PHASE)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_word(CMD_ARM, $urandom(), 8'($urandom_range(255)));
                counted++;
            end
            else if (pick < 11)
            begin
                send_word(CMD_STOP, $urandom(), 8'($urandom_range(255)));
                counted++;
            end
            else if (pick < 14)
            begin
                send_word(CMD_SPARE, $urandom(), 8'($urandom_range(255)));
            end
            else if (pick < 20)
            begin
                send_word(CMD_TICK, $urandom(), 8'($urandom_range(255)));
            end
            else
            begin
                span = (fx_mode == MODE_FLASH) ? {17'd0, fx_period[15:1]}
                                               : {20'd0, fx_period[15:4]};
                sim_now = sim_now + $urandom_range(0, span + span / 4 + 1);
                send_word(CMD_TICK, sim_now, 8'($urandom_range(LAMPS - 1)));
                counted++;
            end
        end
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            run_phase();
            unique case (p % 4)
                0:
                begin
                    tx_gap_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_gap_pct = 70;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_gap_pct = 0;
                    rx_stall_pct = 70;
                end
                default:
                begin
                    tx_gap_pct = 36;
                    rx_stall_pct = 36;
                end
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lamp_states.size() == 0)
            begin
                report_mismatch($sformatf("unexpected lamp %0d state", out_data.lamp_out));
            end
            else
            begin
                head_lamp = pending_lamp_states.pop_front();
                if (out_data.lamp_out !== head_lamp.lamp_out)
                begin
                    report_mismatch($sformatf("lamp_out %0d, expected %0d",
                                              out_data.lamp_out, head_lamp.lamp_out));
                end
                if (out_data.lamp_on !== head_lamp.lamp_on)
                begin
                    report_mismatch($sformatf("lamp_on %0b, expected %0b for lamp %0d",
                                              out_data.lamp_on, head_lamp.lamp_on,
                                              head_lamp.lamp_out));
                end
                if (out_data.dim_level !== head_lamp.dim_level)
                begin
                    report_mismatch($sformatf("dim_level %0d, expected %0d for lamp %0d",
                                              out_data.dim_level, head_lamp.dim_level,
                                              head_lamp.lamp_out));
                end
                lamps_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog expired with %0d lamp states outstanding.",
                     pending_lamp_states.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_quiet_after_reset();
        test_flash_directed();
        test_glow_directed();
        test_random_mix();
        settle();
        $display("Sent %0d words under %0d register settings with four handshake pressure mixes.",
                 words_sent, settings_applied);
        $display("Compared %0d lamp states, %0d mismatches.", lamps_checked, mismatches);
        if (mismatches == 0 && pending_lamp_states.size() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/lfg_pkg.sv
rtl/lfg_cfg_regs.sv
rtl/lfg_engine.sv
rtl/lamp_flash_glow_sequencer_core.sv
tb/tb_top.sv
